>>> rtl/tvm_pkg.sv
// Package for the ternary-weight matrix-vector block: widths, codes and shared types.
// Used by tvm_lane, tvm_merge and the top level; depends on nothing else.
`timescale 1ns / 1ps
package tvm_pkg;

    // Geometry of the activation vector and the four trit lanes.
    localparam int LANES      = 4;
    localparam int MAX_COLS   = 1024;
    localparam int BANK_DEPTH = MAX_COLS / LANES;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int INDEX_W    = $clog2(MAX_COLS);
    localparam int NBYTES_W   = BANK_AW + 1;

    // Field widths.
    localparam int ACT_W    = 8;
    localparam int PROD_W   = ACT_W + 1;
    localparam int SUM_W    = 19;
    localparam int SCALE_W  = 24;
    localparam int SCALED_W = 42;
    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 16;
    localparam int CFG_W    = 16;

    // Reset values of the configuration registers.
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(1024);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(4096);

    // Configuration register indexes.
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // Trit codes; the other two codes decode to zero.
    localparam logic [1:0] TRIT_POS = 2'd1;
    localparam logic [1:0] TRIT_NEG = 2'd2;

    typedef logic signed [ACT_W-1:0]   t_act;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SCALE_W-1:0] t_scale;

    // Control that travels with a weight beat from the read stage to the merge stage.
    typedef struct packed {
        logic valid;
        logic row_end;
        logic last_row;
    } t_row_ctl;

endpackage

>>> rtl/tvm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds one bank of the activation vector.
`timescale 1ns / 1ps
module tvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tvm_lane.sv
// One trit lane: decodes a 2-bit trit and applies it to one activation.
// Depends on tvm_pkg.
`timescale 1ns / 1ps
module tvm_lane
    import tvm_pkg::*;
(
    input  logic [1:0] i_trit,
    input  t_act       i_act,
    output t_prod      o_prod
);

    t_prod w_act_ext;

    assign w_act_ext = PROD_W'(i_act);

    // Plus one passes the activation, minus one negates it, the rest give zero.
    always_comb begin
        unique case (i_trit)
            TRIT_POS: o_prod = w_act_ext;
            TRIT_NEG: o_prod = -w_act_ext;
            default:  o_prod = '0;
        endcase
    end

endmodule

>>> rtl/tvm_merge.sv
// Merge stage: adds the four lane products into the row accumulator and
// registers the finished row. Depends on tvm_pkg.
`timescale 1ns / 1ps
module tvm_merge
    import tvm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_row_ctl i_ctl,
    input  t_scale   i_scale,
    input  t_prod    i_prod [LANES],
    output logic     o_res_valid,
    output t_sum     o_dot,
    output t_scale   o_scale,
    output logic     o_last_row
);

    t_sum   r_acc;
    t_sum   n_acc;
    logic   r_res_valid;
    t_sum   r_dot;
    t_scale r_scale;
    logic   r_last_row;

    // Sum of the lanes and the running row total.
    always_comb begin
        n_acc = r_acc;
        for (int k = 0; k < LANES; k++) begin
            n_acc = n_acc + SUM_W'(i_prod[k]);
        end
    end

    // Accumulator and result valid; the accumulator clears when a row ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_res_valid <= 1'b0;
        end else if (i_en) begin
            r_res_valid <= i_ctl.valid & i_ctl.row_end;
            if (i_ctl.valid) begin
                r_acc <= i_ctl.row_end ? '0 : n_acc;
            end
        end
    end

    // Row result payload.
    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid && i_ctl.row_end) begin
            r_dot      <= n_acc;
            r_scale    <= i_scale;
            r_last_row <= i_ctl.last_row;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_dot       = r_dot;
    assign o_scale     = r_scale;
    assign o_last_row  = r_last_row;

endmodule

>>> rtl/ternary_weight_matvec_top.sv
// Top level of the ternary-weight matrix-vector block: control, activation banks,
// lanes, merge and output scaling. Depends on tvm_pkg, tvm_ram, tvm_lane, tvm_merge.
//
// Usage. Input beats arrive on the s_axis channel; tuser selects the operation.
// A load beat writes one signed activation at act_index; a weight beat carries
// four trits for the next four columns of the current row. The activation
// vector sits in four RAM banks, one per lane, so one weight beat reads all
// four activations at once. After cols_in_use/4 weight beats a row result
// leaves on m_axis: dot_sum and dot_sum times row_scale (Q.16), with tlast
// set on the final row of the matrix.
// Throughput: one beat per cycle, loads and weights alike, unless the output stalls.
// A row result passes registered stages after its last weight beat: the bank read,
// the lane sum and accumulate, then the scale multiply into the output register.
// Reset clears the row and byte counters, the accumulator and the pipeline;
// the activation banks are not cleared and must be loaded before use.
// When a result waits and the receiver stalls, the whole pipeline holds and s_axis_tready falls
// until the waiting result is taken.
// Write the configuration port only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
module ternary_weight_matvec_top
    import tvm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: act_index[9:0], act_value[17:10], weight_byte[25:18],
    //        row_scale[49:26], zero pad[55:50].
    input  logic [55:0]       s_axis_tdata,
    // tuser: operation.
    input  logic              s_axis_tuser,
    // Output stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata: dot_sum[18:0], scaled_sum[60:19], zero pad[63:61].
    output logic [63:0]       m_axis_tdata,
    output logic              m_axis_tlast
);

    // Input field unpacking.
    logic [INDEX_W-1:0] w_act_index;
    t_act               w_act_value;
    logic [7:0]         w_weight_byte;
    t_scale             w_row_scale;

    assign w_act_index   = s_axis_tdata[9:0];
    assign w_act_value   = s_axis_tdata[17:10];
    assign w_weight_byte = s_axis_tdata[25:18];
    assign w_row_scale   = s_axis_tdata[49:26];

    // Configuration registers.
    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLS: r_cols <= i_cfg_data[COLS_W-1:0];
                CFG_ROWS: r_rows <= i_cfg_data[ROWS_W-1:0];
                default:  ;
            endcase
        end
    end

    // Pipeline enable: everything moves unless a result waits at a stalled output.
    logic r_live;
    logic r_o_valid;
    logic w_en;
    logic w_accept;
    logic w_load;
    logic w_weight;

    assign w_en          = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_en && r_live;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (s_axis_tuser == OP_LOAD);
    assign w_weight      = w_accept && (s_axis_tuser == OP_WEIGHT);

    // Bytes per row, clamped to at least one and at most one bank depth.
    logic [NBYTES_W-1:0] w_nbytes_raw;
    logic [NBYTES_W-1:0] w_nbytes;
    logic [ROWS_W-1:0]   w_rows_eff;

    assign w_nbytes_raw = r_cols[COLS_W-1:2];

    always_comb begin
        priority if (w_nbytes_raw == '0) begin
            w_nbytes = NBYTES_W'(1);
        end else if (w_nbytes_raw > NBYTES_W'(BANK_DEPTH)) begin
            w_nbytes = NBYTES_W'(BANK_DEPTH);
        end else begin
            w_nbytes = w_nbytes_raw;
        end
    end

    assign w_rows_eff = (r_rows == '0) ? ROWS_W'(1) : r_rows;

    // Byte and row position within the matrix.
    logic [BANK_AW-1:0] r_pos;
    logic [ROWS_W-1:0]  r_row;
    logic               w_row_end;
    logic               w_last_row;

    assign w_row_end  = ({1'b0, r_pos} + NBYTES_W'(1)) >= w_nbytes;
    assign w_last_row = ({1'b0, r_row} + (ROWS_W + 1)'(1)) >= {1'b0, w_rows_eff};

    // Counters and read-stage control; counters advance on each accepted weight beat.
    t_row_ctl r_a_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= 1'b0;
            r_pos     <= '0;
            r_row     <= '0;
            r_a_ctl   <= '0;
        end else begin
            r_live <= 1'b1;
            if (w_weight) begin
                r_pos <= w_row_end ? '0 : r_pos + BANK_AW'(1);
                if (w_row_end) begin
                    r_row <= w_last_row ? '0 : r_row + ROWS_W'(1);
                end
            end
            if (w_en) begin
                r_a_ctl.valid    <= w_weight;
                r_a_ctl.row_end  <= w_row_end;
                r_a_ctl.last_row <= w_last_row;
            end
        end
    end

    // Read-stage payload.
    logic [7:0] r_a_wbyte;
    t_scale     r_a_scale;

    always_ff @(posedge i_clk) begin
        if (w_weight) begin
            r_a_wbyte <= w_weight_byte;
            r_a_scale <= w_row_scale;
        end
    end

    // Activation banks and trit lanes: column 4b+k lives in bank k at address b.
    t_act  w_bank_rdata [LANES];
    t_prod w_prod       [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic w_bank_we;

        assign w_bank_we = w_load && (w_act_index[1:0] == 2'(k));

        tvm_ram #(
            .WIDTH (ACT_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_bank_we),
            .i_waddr (w_act_index[INDEX_W-1:2]),
            .i_wdata (w_act_value),
            .i_re    (w_weight),
            .i_raddr (r_pos),
            .o_rdata (w_bank_rdata[k])
        );

        tvm_lane u_lane (
            .i_trit (r_a_wbyte[2*k+1:2*k]),
            .i_act  (w_bank_rdata[k]),
            .o_prod (w_prod[k])
        );
    end

    // Merge of the lanes into the row total.
    logic   w_res_valid;
    t_sum   w_dot;
    t_scale w_scale;
    logic   w_res_last;

    tvm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (r_a_ctl),
        .i_scale     (r_a_scale),
        .i_prod      (w_prod),
        .o_res_valid (w_res_valid),
        .o_dot       (w_dot),
        .o_scale     (w_scale),
        .o_last_row  (w_res_last)
    );

    // Scale multiply into the output register.
    logic signed [SCALED_W:0]   w_scaled_full;
    t_sum                       r_o_dot;
    logic signed [SCALED_W-1:0] r_o_scaled;
    logic                       r_o_last;

    assign w_scaled_full = w_dot * w_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_res_valid) begin
            r_o_dot    <= w_dot;
            r_o_scaled <= w_scaled_full[SCALED_W-1:0];
            r_o_last   <= w_res_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b000, r_o_scaled, r_o_dot};
    assign m_axis_tlast  = r_o_last;

endmodule
